[rtl/bitmap_arrow_rotator_macros.svh]
// assertion macros shared by the checkers of the arrow rotator
`ifndef BITMAP_ARROW_ROTATOR_MACROS_SVH
`define BITMAP_ARROW_ROTATOR_MACROS_SVH

// same-cycle implication, masked while reset is applied
`define BAR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap_arrow_rotator check failed");

// next-cycle implication, masked while reset is applied
`define BAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap_arrow_rotator check failed");

// next-cycle implication that also holds through reset
`define BAR_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bitmap_arrow_rotator check failed");

`endif

[rtl/bar_pkg.sv]
`default_nettype none

package bar_pkg;

  // q1.14 fixed point
  localparam int Q_FRAC  = 14;
  localparam int Q_ONE   = 16384;
  localparam int Y_SHIFT = 5;

  localparam int ANGLE_W = 9;
  localparam int TRIG_W  = 16;  // signed, holds +/-16384
  localparam int OFS_W   = 8;   // signed doubled offset from the arrow centre
  localparam int PROD_W  = TRIG_W + OFS_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int COORD_W = 9;

  localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
  localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
  localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
  localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin;
    logic signed [TRIG_W-1:0] cos;
  } trig_t;

  localparam logic [14:0] QSINE [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // sine of a whole-degree angle in 0..359, quadrant folding of the table
  function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] rem;
    logic [6:0]         idx;
    logic               neg;
    logic [TRIG_W-1:0]  mag;
    if (a < DEG_90) begin
      rem = a;
      idx = rem[6:0];
      neg = 1'b0;
    end else if (a < DEG_180) begin
      rem = a - DEG_90;
      idx = 7'(DEG_90 - rem);
      neg = 1'b0;
    end else if (a < DEG_270) begin
      rem = a - DEG_180;
      idx = rem[6:0];
      neg = 1'b1;
    end else begin
      rem = a - DEG_270;
      idx = 7'(DEG_90 - rem);
      neg = 1'b1;
    end
    mag = {1'b0, QSINE[idx]};
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

[rtl/bar_trig.sv]
`default_nettype none

module bar_trig
  import bar_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [ANGLE_W-1:0] wr_data,
  output trig_t                   trig
);

  trig_t              trig_r;
  trig_t              trig_nxt;
  logic [ANGLE_W-1:0] ang;
  logic [ANGLE_W:0]   ang_cos;

  always_comb begin
    ang     = (wr_data >= DEG_360) ? wr_data - DEG_360 : wr_data;
    ang_cos = {1'b0, ang} + {1'b0, DEG_90};
    if (ang_cos >= {1'b0, DEG_360}) begin
      ang_cos = ang_cos - {1'b0, DEG_360};
    end
    trig_nxt     = trig_r;
    if (wr_en) begin
      trig_nxt.sin = sine_q14(ang);
      trig_nxt.cos = sine_q14(ang_cos[ANGLE_W-1:0]);
    end
  end

  // reset angle is zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r.sin <= '0;
      trig_r.cos <= TRIG_W'(Q_ONE);
    end else begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

`default_nettype wire

[rtl/bar_rotate.sv]
`default_nettype none

module bar_rotate
  import bar_pkg::*;
#(
  parameter int ARROW_WIDTH   = 32,
  parameter int ARROW_HEIGHT  = 32,
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  trig_t                          trig,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [5:0]                src_col,
  input  wire logic [5:0]                src_row,
  input  wire logic [7:0]                page_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [COORD_W-1:0]      screen_x,
  output logic signed [COORD_W-1:0]      screen_y,
  output logic                           pixel_on
);

  localparam logic signed [SUM_W-1:0] X_OFS = SUM_W'(SCREEN_WIDTH * Q_ONE);
  localparam logic signed [SUM_W-1:0] Y_OFS = SUM_W'((SCREEN_HEIGHT + 2 * Y_SHIFT) * Q_ONE);
  localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(1 << Q_FRAC);

  // stage 1: doubled offsets
  logic                     v1_r;
  logic signed [OFS_W-1:0]  dx2_r, dy2_r;
  logic                     pix1_r;
  // stage 2: products
  logic                     v2_r;
  logic signed [PROD_W-1:0] cx_r, sy_r, sx_r, cy_r;
  logic                     pix2_r;
  // stage 3: results
  logic                     v3_r;
  logic signed [COORD_W-1:0] sx_out_r, sy_out_r;
  logic                     pix3_r;

  logic adv1, adv2, adv3;
  logic signed [SUM_W-1:0]  nx, ny;
  logic [COORD_W-1:0]       rx_nxt, ry_nxt;

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  function automatic logic [COORD_W-1:0] round_q15(input logic signed [SUM_W-1:0] n);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] q;
    if (!n[SUM_W-1]) begin
      mag = $unsigned(n) + $unsigned(HALF);
      q   = mag >> (Q_FRAC + 1);
    end else begin
      mag = $unsigned(-n) + $unsigned(HALF);
      q   = -(mag >> (Q_FRAC + 1));
    end
    return q[COORD_W-1:0];
  endfunction

  always_comb begin
    nx     = SUM_W'(cx_r) - SUM_W'(sy_r) + X_OFS;
    ny     = SUM_W'(sx_r) + SUM_W'(cy_r) + Y_OFS;
    rx_nxt = round_q15(nx);
    ry_nxt = round_q15(ny);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      dx2_r  <= $signed({1'b0, src_col, 1'b0}) - OFS_W'(ARROW_WIDTH);
      dy2_r  <= $signed({1'b0, src_row, 1'b0}) - OFS_W'(ARROW_HEIGHT);
      pix1_r <= page_byte[src_row[2:0]];
    end
    if (adv2 && v1_r) begin
      cx_r   <= trig.cos * dx2_r;
      sy_r   <= trig.sin * dy2_r;
      sx_r   <= trig.sin * dx2_r;
      cy_r   <= trig.cos * dy2_r;
      pix2_r <= pix1_r;
    end
    if (adv3 && v2_r) begin
      sx_out_r <= $signed(rx_nxt);
      sy_out_r <= $signed(ry_nxt);
      pix3_r   <= pix2_r;
    end
  end

  assign out_valid = v3_r;
  assign screen_x  = sx_out_r;
  assign screen_y  = sy_out_r;
  assign pixel_on  = pix3_r;

endmodule

`default_nettype wire

[rtl/bitmap_arrow_rotator.sv]
`default_nettype none

// Rotates one pixel of a page-packed arrow bitmap per transfer and places it
// on the screen: the pixel at (src_col, src_row) is taken from bit
// (src_row mod 8) of page_byte, its offset from the arrow centre is rotated
// by the configured angle in whole degrees (q1.14 sine/cosine from a
// quarter-wave table), moved so the arrow centre lands on the screen centre
// shifted down by 5 rows, and rounded half away from zero. Coordinates are
// signed and not clipped. Throughput is one pixel per clock while out_ready
// stays high. Each pixel is registered through the offset stage, the
// four-multiplier product stage and the sum-and-round stage, and out_valid
// rises when it reaches the last. A write on cfg_wr_en loads the angle
// (values 360..511 wrap by 360); it applies to every pixel that enters the
// product stage after the write is registered; reset selects angle zero.

module bitmap_arrow_rotator
  import bar_pkg::*;
#(
  parameter int ARROW_WIDTH   = 32,
  parameter int ARROW_HEIGHT  = 32,
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // angle register write
  input  wire logic                 cfg_wr_en,
  input  wire logic [ANGLE_W-1:0]   cfg_wr_data,
  // source pixel channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [5:0]           in_src_col,
  input  wire logic [5:0]           in_src_row,
  input  wire logic [7:0]           in_page_byte,
  // screen pixel channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [COORD_W-1:0] out_screen_x,
  output logic signed [COORD_W-1:0] out_screen_y,
  output logic                      out_pixel_on
);

  // sine and cosine of the current angle, looked up once per write
  trig_t trig;

  bar_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr_en),
    .wr_data (cfg_wr_data),
    .trig    (trig)
  );

  // three-stage rotate pipeline, each stage stalls only when the one after is full
  bar_rotate #(
    .ARROW_WIDTH   (ARROW_WIDTH),
    .ARROW_HEIGHT  (ARROW_HEIGHT),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .trig      (trig),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src_col   (in_src_col),
    .src_row   (in_src_row),
    .page_byte (in_page_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .screen_x  (out_screen_x),
    .screen_y  (out_screen_y),
    .pixel_on  (out_pixel_on)
  );

endmodule

`default_nettype wire

[rtl/bar_checker.sv]
`default_nettype none

`include "bitmap_arrow_rotator_macros.svh"

module bar_checker
  import bar_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic [5:0]           in_src_col,
  input wire logic [5:0]           in_src_row,
  input wire logic [7:0]           in_page_byte,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [COORD_W-1:0]   out_screen_x,
  input wire logic [COORD_W-1:0]   out_screen_y,
  input wire logic                 out_pixel_on
);

  // a stalled result holds
  `BAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_screen_x) && $stable(out_screen_y) && $stable(out_pixel_on))

  // a waiting source pixel holds
  `BAR_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(in_src_col) && $stable(in_src_row) && $stable(in_page_byte))

  // reset empties the pipeline
  `BAR_ASSERT_NEXT_ALWAYS(a_rst_empty, !rst_n, !out_valid)

  // with the result stage empty the pipeline can always take a pixel
  `BAR_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

  // a drained, idle pipeline shows no result next cycle
  `BAR_ASSERT_NEXT(a_no_phantom, !out_valid && !in_valid && $past(!in_valid) &&
    $past(!in_valid, 2), !out_valid)

endmodule

bind bitmap_arrow_rotator bar_checker u_bar_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_src_col   (in_src_col),
  .in_src_row   (in_src_row),
  .in_page_byte (in_page_byte),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_screen_x (out_screen_x),
  .out_screen_y (out_screen_y),
  .out_pixel_on (out_pixel_on)
);

`default_nettype wire

[sim/bitmap_arrow_rotator_tb.sv]
`default_nettype none

module bitmap_arrow_rotator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bar_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 6;
  // input transfer to result valid, plus a little margin before config writes
  localparam int PIPE_DEPTH       = 3;
  localparam int SETTLE_CYCLES    = PIPE_DEPTH + 3;
  localparam int ARROW_W          = 32;
  localparam int ARROW_H          = 32;
  localparam int SCREEN_W         = 84;
  localparam int SCREEN_H         = 48;
  localparam longint HALF_OUT_LSB = 64'sd1 <<< Q_FRAC;  // half of the 2^15 divisor
  localparam int RANDOM_PHASES    = 16;
  localparam int PIXELS_PER_PHASE = 104;
  localparam int BURST_PIXELS     = 48;
  localparam int HOLD_CYCLES      = 300;
  localparam int PRESSURE_PHASE   = 5;
  localparam int N_DIRECTED       = 24;

  // idling modes, one per random phase in turn
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      on;
  } screen_pixel_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [5:0]         col;
    logic [5:0]         row;
    logic [7:0]         page;
    logic               known;  // want holds a hand-worked result
    screen_pixel_t      want;
  } pixel_case_t;

  localparam screen_pixel_t FROM_PREDICTOR = '0;

  // directed rows: reset angle, corners of the source field, the four right
  // angles, angles past 359 that wrap, rows and columns beyond the arrow,
  // results left of and above the screen
  localparam pixel_case_t DIRECTED [N_DIRECTED] = '{
    '{9'd0,   6'd16, 6'd16, 8'h01, 1'b1, '{9'sd42, 9'sd29, 1'b1}},
    '{9'd0,   6'd0,  6'd0,  8'hFE, 1'b1, '{9'sd26, 9'sd13, 1'b0}},
    '{9'd0,   6'd63, 6'd63, 8'h80, 1'b1, '{9'sd89, 9'sd76, 1'b1}},
    '{9'd0,   6'd63, 6'd0,  8'h00, 1'b1, '{9'sd89, 9'sd13, 1'b0}},
    '{9'd0,   6'd0,  6'd63, 8'hFF, 1'b1, '{9'sd26, 9'sd76, 1'b1}},
    '{9'd0,   6'd31, 6'd32, 8'h04, 1'b1, '{9'sd57, 9'sd45, 1'b0}},
    '{9'd90,  6'd0,  6'd0,  8'h01, 1'b1, '{9'sd58, 9'sd13, 1'b1}},
    '{9'd90,  6'd63, 6'd63, 8'h80, 1'b1, '{-9'sd5, 9'sd76, 1'b1}},
    '{9'd90,  6'd17, 6'd5,  8'h20, 1'b0, FROM_PREDICTOR},
    '{9'd180, 6'd0,  6'd0,  8'h55, 1'b1, '{9'sd58, 9'sd45, 1'b1}},
    '{9'd180, 6'd63, 6'd63, 8'hAA, 1'b1, '{-9'sd5, -9'sd18, 1'b1}},
    '{9'd180, 6'd1,  6'd2,  8'h04, 1'b0, FROM_PREDICTOR},
    '{9'd270, 6'd63, 6'd0,  8'h01, 1'b1, '{9'sd26, -9'sd18, 1'b1}},
    '{9'd270, 6'd0,  6'd63, 8'h80, 1'b1, '{9'sd89, 9'sd45, 1'b1}},
    '{9'd359, 6'd0,  6'd0,  8'h02, 1'b0, FROM_PREDICTOR},
    '{9'd359, 6'd63, 6'd63, 8'h40, 1'b0, FROM_PREDICTOR},
    '{9'd360, 6'd16, 6'd16, 8'h01, 1'b1, '{9'sd42, 9'sd29, 1'b1}},
    '{9'd360, 6'd63, 6'd63, 8'h7F, 1'b1, '{9'sd89, 9'sd76, 1'b0}},
    '{9'd450, 6'd0,  6'd0,  8'h10, 1'b1, '{9'sd58, 9'sd13, 1'b0}},
    '{9'd511, 6'd0,  6'd0,  8'h08, 1'b0, FROM_PREDICTOR},
    '{9'd511, 6'd63, 6'd63, 8'hF7, 1'b0, FROM_PREDICTOR},
    '{9'd45,  6'd3,  6'd7,  8'h80, 1'b0, FROM_PREDICTOR},
    '{9'd45,  6'd40, 6'd50, 8'h3C, 1'b0, FROM_PREDICTOR},
    '{9'd1,   6'd63, 6'd0,  8'hEF, 1'b0, FROM_PREDICTOR}
  };

  // fixed angles for the first random phases: extremes and a bit boundary
  localparam logic [ANGLE_W-1:0] PHASE_ANGLES [6] = '{
    9'd0, 9'd359, 9'd511, 9'd360, 9'd255, 9'd256
  };

  // q1.14 sine of 0..90 degrees
  int quarter_sine [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // dut ports, all inputs known from time zero
  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      cfg_wr_en    = 1'b0;
  logic [ANGLE_W-1:0]        cfg_wr_data  = '0;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic [5:0]                in_src_col   = '0;
  logic [5:0]                in_src_row   = '0;
  logic [7:0]                in_page_byte = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic signed [COORD_W-1:0] out_screen_x;
  logic signed [COORD_W-1:0] out_screen_y;
  logic                      out_pixel_on;

  // screen pixels predicted for accepted transfers, oldest first
  screen_pixel_t screen_pixel_q[$];

  logic [ANGLE_W-1:0] cur_angle     = '0;  // angle the block holds right now
  int                 send_idle_pct = 0;
  int                 stall_pct     = 0;
  int                 hold_len      = 0;
  logic               hold_on       = 1'b0;
  event               hold_go;

  int error_count  = 0;
  int pixels_sent  = 0;
  int results_seen = 0;
  int angle_writes = 0;

  bitmap_arrow_rotator #(
    .ARROW_WIDTH  (ARROW_W),
    .ARROW_HEIGHT (ARROW_H),
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_src_col  (in_src_col),
    .in_src_row  (in_src_row),
    .in_page_byte(in_page_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_screen_x(out_screen_x),
    .out_screen_y(out_screen_y),
    .out_pixel_on(out_pixel_on)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // screen position predictor
  // ---------------------------------------------------------------------------

  // sine of a whole degree in 0..359 by folding the quarter wave
  function automatic int sine_deg(input int deg);
    int quad;
    int rem;
    int mag;
    quad = deg / 90;
    rem  = deg % 90;
    mag  = (quad % 2 == 0) ? quarter_sine[rem] : quarter_sine[90 - rem];
    return (quad >= 2) ? -mag : mag;
  endfunction

  // divide by 2^15, halves go away from zero
  function automatic longint round_half_away(input longint n);
    if (n >= 0) return (n + HALF_OUT_LSB) >>> (Q_FRAC + 1);
    return -((-n + HALF_OUT_LSB) >>> (Q_FRAC + 1));
  endfunction

  function automatic screen_pixel_t rotate_to_screen(input logic [ANGLE_W-1:0] angle,
                                                     input logic [5:0] col,
                                                     input logic [5:0] row,
                                                     input logic [7:0] page);
    int            deg;
    longint        s;
    longint        c;
    longint        dx2;
    longint        dy2;
    longint        nx;
    longint        ny;
    screen_pixel_t p;
    deg = int'(angle);
    if (deg >= 360) deg -= 360;
    s = sine_deg(deg);
    c = sine_deg((deg + 90) % 360);
    // offsets from the arrow centre in half pixels
    dx2 = 2 * longint'(col) - ARROW_W;
    dy2 = 2 * longint'(row) - ARROW_H;
    // screen centre, moved down by the y shift, also in half pixels
    nx = c * dx2 - s * dy2 + longint'(SCREEN_W) * Q_ONE;
    ny = s * dx2 + c * dy2 + longint'(SCREEN_H + 2 * Y_SHIFT) * Q_ONE;
    p.x  = COORD_W'(round_half_away(nx));
    p.y  = COORD_W'(round_half_away(ny));
    p.on = page[row[2:0]];
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready, long hold-off, checking
  // ---------------------------------------------------------------------------

  // hold-off counted here, independent of the sender
  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (hold_on) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    error_count++;
  endtask

  // sample at the rising edge, compare at the falling edge so that a prediction
  // pushed at the same rising edge is always in place
  always @(posedge clk) begin
    screen_pixel_t got;
    screen_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      got.x  = out_screen_x;
      got.y  = out_screen_y;
      got.on = out_pixel_on;
      @(negedge clk);
      if (screen_pixel_q.size() == 0) begin
        report_mismatch($sformatf("transfer (%0d, %0d, %0b) with nothing pending",
                                  got.x, got.y, got.on));
      end else begin
        want = screen_pixel_q.pop_front();
        if (got.x !== want.x)
          report_mismatch($sformatf("screen_x %0d, expected %0d", got.x, want.x));
        if (got.y !== want.y)
          report_mismatch($sformatf("screen_y %0d, expected %0d", got.y, want.y));
        if (got.on !== want.on)
          report_mismatch($sformatf("pixel_on %0b, expected %0b", got.on, want.on));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // source side
  // ---------------------------------------------------------------------------

  // random idle cycles, then hold the pixel until it transfers
  task automatic offer_pixel(input logic [5:0] col, input logic [5:0] row,
                             input logic [7:0] page, input screen_pixel_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_src_col   <= col;
    in_src_row   <= row;
    in_page_byte <= page;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    screen_pixel_q.push_back(want);
    pixels_sent++;
  endtask

  // half the pixels inside the arrow, half anywhere in the 6-bit field
  task automatic offer_random_pixel();
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] page;
    col  = $urandom_range(1) ? 6'($urandom) : 6'($urandom_range(ARROW_W - 1));
    row  = $urandom_range(1) ? 6'($urandom) : 6'($urandom_range(ARROW_H - 1));
    page = 8'($urandom);
    offer_pixel(col, row, page, rotate_to_screen(cur_angle, col, row, page));
  endtask

  // stop offering and let every pending result come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (screen_pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the pipeline empty
  task automatic load_angle(input logic [ANGLE_W-1:0] angle);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= angle;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_angle = angle;
    angle_writes++;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 82 : (mode == IDLE_BOTH) ? 16 : 0;
    stall_pct    <= (mode == IDLE_RECEIVER) ? 82 : (mode == IDLE_BOTH) ? 16 : 0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    pixel_case_t row_case;
    logic [ANGLE_W-1:0] phase_angle;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, no idling; first rows run on the reset angle
    set_idling(IDLE_NONE);
    for (int k = 0; k < N_DIRECTED; k++) begin
      row_case = DIRECTED[k];
      if (row_case.angle != cur_angle) begin
        wait_drained();
        load_angle(row_case.angle);
      end
      offer_pixel(row_case.col, row_case.row, row_case.page,
                  row_case.known ? row_case.want
                                 : rotate_to_screen(cur_angle, row_case.col,
                                                    row_case.row, row_case.page));
    end

    // random phases, each on its own angle and idling mode
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      phase_angle = (ph < 6) ? PHASE_ANGLES[ph] : ANGLE_W'($urandom_range(511));
      load_angle(phase_angle);
      set_idling(idle_mode_t'(ph % 4));
      for (int k = 0; k < PIXELS_PER_PHASE; k++) offer_random_pixel();

      if (ph == PRESSURE_PHASE) begin
        // receiver holds off while the sender keeps pushing: pipeline fills
        // and in_ready has to drop
        wait_drained();
        set_idling(IDLE_NONE);
        hold_len = HOLD_CYCLES;
        -> hold_go;
        for (int k = 0; k < BURST_PIXELS; k++) offer_random_pixel();
      end
    end

    wait_drained();

    $display("covered %0d pixels over %0d angle writes, %0d results checked",
             pixels_sent, angle_writes, results_seen);
    $display("idling: none, sender, receiver, both; one %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // safety net, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results pending", screen_pixel_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
